// File: design/indentation_level_tracker_top_macros.svh
// Assertion macros shared by the indentation level tracker RTL.
`ifndef INDENTATION_LEVEL_TRACKER_TOP_MACROS_SVH
`define INDENTATION_LEVEL_TRACKER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising edge outside reset.
`define ITR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define ITR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define ITR_ASSERT(label, clk, rst_n, prop, msg)
`define ITR_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// File: design/itr_pkg.sv
// Types and constants shared by the indentation level tracker modules.
`default_nettype none

package itr_pkg;

  localparam int WIDTH_W = 7;  // indentation width field
  localparam int CNT_W   = 6;  // dedent count field

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    KIND_SAME = 2'd0,
    KIND_PUSH = 2'd1,
    KIND_POP  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNEXPECTED = 3'd1,
    ERR_EXPECTED   = 3'd2,
    ERR_MISMATCH   = 3'd3,
    ERR_MAX_DEPTH  = 3'd4,
    ERR_TOO_WIDE   = 3'd5
  } err_t;

  // Summary of one classified line, passed from front to back.
  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic               block_pending;
    logic               too_wide;
  } line_info_t;

  // One result beat.
  typedef struct packed {
    kind_t              kind;
    logic [CNT_W-1:0]   pops;
    err_t               err;
    logic [WIDTH_W-1:0] width;
  } result_t;

endpackage

`default_nettype wire

// File: design/itr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module itr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one entry, register the read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: design/itr_fifo.sv
// Small register queue with full and empty flags.
`default_nettype none

module itr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push_ok, pop_ok;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers and track the fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming beat.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: design/itr_front.sv
// Front end: gathers leading whitespace and classifies each line.
`default_nettype none

module itr_front #(
  parameter int MAX_INDENT_WIDTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  input  wire logic [7:0]                  in_character,
  input  wire logic                        in_line_start,
  input  wire logic                        in_opens_block,
  output logic                             in_full,
  input  wire logic                        rec_full,
  output logic                             rec_push,
  output itr_pkg::line_info_t              rec_info,
  output logic [MAX_INDENT_WIDTH-1:0]      rec_pattern
);

  import itr_pkg::*;

  localparam int PW  = MAX_INDENT_WIDTH;
  localparam int PIW = (PW > 1) ? $clog2(PW) : 1;

  logic [PW-1:0]      lp_r, lp_nxt;
  logic [WIDTH_W-1:0] lw_r, lw_nxt;
  logic               eval_r, eval_nxt;
  logic               bp_r, bp_nxt;

  logic [PW-1:0]      eff_lp;
  logic [WIDTH_W-1:0] eff_lw;
  logic               eff_eval, eff_bp;
  logic               accept, is_ws, room;

  assign in_full = rec_full;
  assign accept  = in_push && !rec_full;

  // Line start restarts the line before this beat is looked at.
  always_comb begin
    eff_lp   = in_line_start ? '0 : lp_r;
    eff_lw   = in_line_start ? '0 : lw_r;
    eff_eval = in_line_start ? 1'b0 : eval_r;
    eff_bp   = in_line_start ? in_opens_block : bp_r;
    is_ws    = (in_character == CH_SPACE) || (in_character == CH_TAB);
    room     = (eff_lw < WIDTH_W'(MAX_INDENT_WIDTH));
  end

  // Gather indentation or close the line with one record.
  always_comb begin
    lp_nxt      = lp_r;
    lw_nxt      = lw_r;
    eval_nxt    = eval_r;
    bp_nxt      = bp_r;
    rec_push    = 1'b0;
    rec_info    = '{width: eff_lw, block_pending: eff_bp, too_wide: is_ws};
    rec_pattern = eff_lp;
    if (accept) begin
      lp_nxt   = eff_lp;
      lw_nxt   = eff_lw;
      eval_nxt = eff_eval;
      bp_nxt   = eff_bp;
      if (!eff_eval) begin
        if (is_ws && room) begin
          lp_nxt[eff_lw[PIW-1:0]] = (in_character == CH_TAB);
          lw_nxt = eff_lw + WIDTH_W'(1);
        end else begin
          eval_nxt = 1'b1;
          bp_nxt   = 1'b0;
          rec_push = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r   <= '0;
      eval_r <= 1'b1;
      bp_r   <= 1'b0;
    end else begin
      lw_r   <= lw_nxt;
      eval_r <= eval_nxt;
      bp_r   <= bp_nxt;
    end
  end

  // Hold the pattern; only meaningful after a line start.
  always_ff @(posedge clk) begin
    lp_r <= lp_nxt;
  end

endmodule

`default_nettype wire

// File: design/itr_back.sv
// Back end: compares each line against the level stack and emits results.
`default_nettype none

`include "indentation_level_tracker_top_macros.svh"

module itr_back #(
  parameter int MAX_LEVELS       = 32,
  parameter int MAX_INDENT_WIDTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rec_empty,
  input  wire itr_pkg::line_info_t         rec_info,
  input  wire logic [MAX_INDENT_WIDTH-1:0] rec_pattern,
  output logic                             rec_pop,
  input  wire logic                        res_full,
  output logic                             res_push,
  output itr_pkg::result_t                 res_data
);

  import itr_pkg::*;

  localparam int PW = MAX_INDENT_WIDTH;
  localparam int AW = $clog2(MAX_LEVELS);

  typedef enum logic [1:0] {
    ST_EVAL  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      lc_r, lc_nxt;
  logic [WIDTH_W-1:0] top_width_r, top_width_nxt;
  logic [PW-1:0]      top_pattern_r, top_pattern_nxt;
  logic [CNT_W-1:0]   pops_r, pops_nxt;

  logic [PW-1:0]      mask_n, mask_w, diff;
  logic               ok_n, ok_w;
  logic [WIDTH_W-1:0] n;
  logic               done;
  result_t            res;

  logic               ram_wr_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [WIDTH_W-1:0] ram_rd_data;

  // Width of every level on the stack.
  itr_ram #(
    .WIDTH(WIDTH_W),
    .DEPTH(MAX_LEVELS)
  ) u_width_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(lc_r),
    .wr_data(n),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Entry under the current top, read while a pop is taken.
  assign ram_rd_addr = lc_r - AW'(2);
  assign n           = rec_info.width;

  // Prefix compare of the line pattern against the top pattern.
  always_comb begin
    for (int i = 0; i < PW; i++) begin
      mask_n[i] = (WIDTH_W'(i) < n);
      mask_w[i] = (WIDTH_W'(i) < top_width_r);
    end
    diff = rec_pattern ^ top_pattern_r;
    ok_n = ~|(diff & mask_n);
    ok_w = ~|(diff & mask_w);
  end

  // Evaluate the head record; walk the stack one pop at a time.
  always_comb begin
    state_nxt       = state_r;
    lc_nxt          = lc_r;
    top_width_nxt   = top_width_r;
    top_pattern_nxt = top_pattern_r;
    pops_nxt        = pops_r;
    ram_wr_en       = 1'b0;
    done            = 1'b0;
    res             = '{kind: KIND_SAME, pops: '0, err: ERR_NONE, width: n};
    case (state_r)
      ST_EVAL: begin
        if (!rec_empty) begin
          if (rec_info.too_wide) begin
            res.err = ERR_TOO_WIDE;
            done    = 1'b1;
          end else if (rec_info.block_pending) begin
            done = 1'b1;
            if (n <= top_width_r) begin
              res.err = ERR_EXPECTED;
            end else if (!ok_w) begin
              res.err = ERR_MISMATCH;
            end else if (lc_r == AW'(MAX_LEVELS - 1)) begin
              res.err = ERR_MAX_DEPTH;
            end else begin
              res.kind = KIND_PUSH;
              if (!res_full) begin
                ram_wr_en       = 1'b1;
                lc_nxt          = lc_r + AW'(1);
                top_width_nxt   = n;
                top_pattern_nxt = rec_pattern;
              end
            end
          end else if (pops_r == '0 && n > top_width_r) begin
            res.err = ERR_UNEXPECTED;
            done    = 1'b1;
          end else if (lc_r != '0 && n < top_width_r && ok_n) begin
            lc_nxt    = lc_r - AW'(1);
            pops_nxt  = pops_r + CNT_W'(1);
            state_nxt = ST_FETCH;
          end else begin
            done     = 1'b1;
            res.pops = pops_r;
            res.kind = (pops_r != '0) ? KIND_POP : KIND_SAME;
            if (lc_r != '0 && !(n == top_width_r && ok_n)) begin
              res.err = ERR_MISMATCH;
            end
            if (!res_full) begin
              top_pattern_nxt = top_pattern_r & mask_w;
            end
          end
          if (done && !res_full) begin
            pops_nxt = '0;
          end
        end
      end
      ST_FETCH: begin
        top_width_nxt = (lc_r == '0) ? '0 : ram_rd_data;
        state_nxt     = ST_EVAL;
      end
      default: begin
        state_nxt = ST_EVAL;
      end
    endcase
  end

  assign res_push = done && !res_full;
  assign rec_pop  = res_push;
  assign res_data = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_EVAL;
      lc_r          <= '0;
      top_width_r   <= '0;
      top_pattern_r <= '0;
      pops_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      lc_r          <= lc_nxt;
      top_width_r   <= top_width_nxt;
      top_pattern_r <= top_pattern_nxt;
      pops_r        <= pops_nxt;
    end
  end

  `ITR_ASSERT_NEVER(a_lc_limit, clk, rst_n, lc_r > AW'(MAX_LEVELS - 1), "stack depth past limit")
  `ITR_ASSERT(a_fetch_return, clk, rst_n, state_r == ST_FETCH |=> state_r == ST_EVAL, "fetch did not return")
  `ITR_ASSERT(a_empty_width, clk, rst_n, (state_r == ST_EVAL && lc_r == '0) |-> top_width_r == '0, "empty stack has width")
  `ITR_ASSERT(a_push_room, clk, rst_n, res_push |-> (!res_full && !rec_empty), "result beat without room or record")

endmodule

`default_nettype wire

// File: design/indentation_level_tracker_top.sv
// Indentation level tracker: front end, line queue, stack back end, result queue.
// Flow: a line's record passes through the line queue and the back end into the result
//   queue; each level popped adds one EVAL then FETCH pass (stack RAM read loop).
// Throughput: one character per cycle while the line queue has room; a line
//   that pops levels holds the back end for an EVAL then FETCH pass per level popped.
// Reset: synchronous, active low; clears depth, top pattern, line state and queues.
//   The width RAM is not cleared; entries are read only after being pushed.
`default_nettype none

module indentation_level_tracker_top #(
  parameter int MAX_LEVELS       = 32,
  parameter int MAX_INDENT_WIDTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_character,
  input  wire logic       in_line_start,
  input  wire logic       in_opens_block,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [1:0]      out_result_kind,
  output logic [5:0]      out_dedent_count,
  output logic [2:0]      out_error_code,
  output logic [6:0]      out_indent_width
);

  import itr_pkg::*;

  localparam int PW    = MAX_INDENT_WIDTH;
  localparam int REC_W = $bits(line_info_t) + PW;

  logic          rec_push, rec_full, rec_pop, rec_empty;
  line_info_t    front_info, back_info;
  logic [PW-1:0] front_pattern, back_pattern;
  logic          res_push, res_full;
  result_t       res_wr, res_rd;

  itr_front #(
    .MAX_INDENT_WIDTH(MAX_INDENT_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_character  (in_character),
    .in_line_start (in_line_start),
    .in_opens_block(in_opens_block),
    .in_full       (in_full),
    .rec_full      (rec_full),
    .rec_push      (rec_push),
    .rec_info      (front_info),
    .rec_pattern   (front_pattern)
  );

  // Decouple classification from stack evaluation.
  itr_fifo #(
    .W    (REC_W),
    .DEPTH(2)
  ) u_line_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (rec_push),
    .wr_data({front_info, front_pattern}),
    .full   (rec_full),
    .pop    (rec_pop),
    .rd_data({back_info, back_pattern}),
    .empty  (rec_empty)
  );

  itr_back #(
    .MAX_LEVELS      (MAX_LEVELS),
    .MAX_INDENT_WIDTH(MAX_INDENT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_empty  (rec_empty),
    .rec_info   (back_info),
    .rec_pattern(back_pattern),
    .rec_pop    (rec_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_wr)
  );

  // Hold finished results until popped.
  itr_fifo #(
    .W    ($bits(result_t)),
    .DEPTH(2)
  ) u_result_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(res_wr),
    .full   (res_full),
    .pop    (out_pop),
    .rd_data(res_rd),
    .empty  (out_empty)
  );

  assign out_result_kind  = res_rd.kind;
  assign out_dedent_count = res_rd.pops;
  assign out_error_code   = res_rd.err;
  assign out_indent_width = res_rd.width;

endmodule

`default_nettype wire
